@@ hdl/mp2d_pkg.sv @@
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants for the streaming 2-D max pooling block: default sizes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    localparam int DEF_MAX_WINDOW  = 8;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;
    localparam int FRAME_BITS     = 11;
    localparam int WIN_BITS       = 4;
    localparam int OUT_POS_BITS   = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP         = 3'd3;

    localparam logic [FRAME_BITS-1:0] RST_FRAME_HEIGHT = 11'd32;
    localparam logic [FRAME_BITS-1:0] RST_FRAME_WIDTH  = 11'd32;
    localparam logic [WIN_BITS-1:0]   RST_WINDOW_SIZE  = 4'd2;
    localparam logic [WIN_BITS-1:0]   RST_STEP         = 4'd0;

endpackage

@@ hdl/max_pool_2d_stream.sv @@
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over raster-ordered planes, with a line store
// holding the last window_size rows and a sequential window scan.
// ----------------------------------------------------------------------------
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// sample in | i_valid, o_ready, i_sample                | in
// result    | o_valid, i_ready, o_pooled_max, o_out_row,| out
//           | o_out_col, o_plane_done, o_config_error   |
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in
//           | i_cfg_data                                |
//
// A sample without a result is taken while the block stays idle; a sample
// under an unusable configuration passes through the done state. A sample
// that completes a window starts a scan: the window is read from the
// single-port line store one entry a cycle, K*K reads, then the registered
// read data is awaited, the scan closes and the output register is loaded.
// Reset is synchronous; it restores the registers to 32, 32, 2, 0 and the
// position to the plane origin. The line store is not cleared. A stalled
// result holds in the output register while the next sample transfer is
// taken; a further result waits in the done state until the register frees.
// ----------------------------------------------------------------------------
module max_pool_2d_stream
    import mp2d_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_max,
    output logic [OUT_POS_BITS-1:0]       o_out_row,
    output logic [OUT_POS_BITS-1:0]       o_out_col,
    output logic                          o_plane_done,
    output logic                          o_config_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int PX0   = ((MW + 1) > FRAME_BITS) ? (MW + 1) : FRAME_BITS;
    localparam int PX    = PX0 + 1;
    localparam int AW    = SW + CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state r_state;

    logic [FRAME_BITS-1:0] r_frame_height;
    logic [FRAME_BITS-1:0] r_frame_width;
    logic [WIN_BITS-1:0]   r_window_size;
    logic [WIN_BITS-1:0]   r_step;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [SW-1:0] r_row_phase, n_row_phase;
    logic [SW-1:0] r_col_phase, n_col_phase;
    logic [SW-1:0] r_slot, n_slot;
    logic [RW-1:0] r_orow, n_orow;
    logic [CW-1:0] r_ocol, n_ocol;

    logic signed [SAMPLE_BITS-1:0] r_line_store [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic                          r_rd_valid;

    logic [SW-1:0] r_scan_slot;
    logic [CW-1:0] r_scan_col;
    logic [CW-1:0] r_scan_start;
    logic [SW-1:0] r_scan_j;
    logic          r_issuing;

    logic signed [SAMPLE_BITS-1:0] r_best;
    logic [OUT_POS_BITS-1:0]       r_res_row;
    logic [OUT_POS_BITS-1:0]       r_res_col;
    logic                          r_res_done;
    logic                          r_res_err;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_max;
    logic [OUT_POS_BITS-1:0]       r_out_row;
    logic [OUT_POS_BITS-1:0]       r_out_col;
    logic                          r_out_done;
    logic                          r_out_err;

    logic [PX-1:0] h_cfg, w_cfg, h_eff, w_eff, k_eff, s_eff;
    logic [PX-1:0] e_r, e_c;
    logic [SW-1:0] e_row_phase, e_col_phase, e_slot;
    logic [RW-1:0] e_orow;
    logic [CW-1:0] e_ocol;
    logic          cfg_err, wrap, hit, row_end, col_fits, row_fits;
    logic          in_xfer, cfg_restart, out_free, last_issue;
    logic [AW-1:0] wr_addr, rd_addr;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    assign cfg_restart = i_cfg_valid && ((i_cfg_index == REG_FRAME_HEIGHT) ||
                         (i_cfg_index == REG_FRAME_WIDTH) ||
                         (i_cfg_index == REG_WINDOW_SIZE) ||
                         (i_cfg_index == REG_STEP));

    always_comb begin
        h_cfg = PX'(r_frame_height);
        w_cfg = PX'(r_frame_width);
        h_eff = (h_cfg > PX'(MAX_HEIGHT)) ? PX'(MAX_HEIGHT) : h_cfg;
        w_eff = (w_cfg > PX'(MAX_WIDTH)) ? PX'(MAX_WIDTH) : w_cfg;
        k_eff = PX'(r_window_size);
        s_eff = (r_step == '0) ? k_eff : PX'(r_step);
        cfg_err = (k_eff == '0) || (k_eff > PX'(MAX_WINDOW)) ||
                  (s_eff > PX'(MAX_WINDOW)) || (h_eff < k_eff) || (w_eff < k_eff);

        wrap = (PX'(r_row) >= h_eff) || (PX'(r_col) >= w_eff);
        e_r         = wrap ? '0 : PX'(r_row);
        e_c         = wrap ? '0 : PX'(r_col);
        e_row_phase = wrap ? '0 : r_row_phase;
        e_col_phase = wrap ? '0 : r_col_phase;
        e_slot      = wrap ? '0 : r_slot;
        e_orow      = wrap ? '0 : r_orow;
        e_ocol      = wrap ? '0 : r_ocol;

        row_fits = (e_r + PX'(1)) >= k_eff;
        col_fits = (e_c + PX'(1)) >= k_eff;
        row_end  = (e_c + PX'(1)) >= w_eff;
        hit = row_fits && col_fits && (e_row_phase == '0) && (e_col_phase == '0);

        n_row       = RW'(e_r);
        n_col       = CW'(e_c);
        n_row_phase = e_row_phase;
        n_col_phase = e_col_phase;
        n_slot      = e_slot;
        n_orow      = e_orow;
        n_ocol      = e_ocol;

        if (col_fits) begin
            n_col_phase = ((PX'(e_col_phase) + PX'(1)) >= s_eff) ? '0 :
                          SW'(PX'(e_col_phase) + PX'(1));
            if (e_col_phase == '0) begin
                n_ocol = e_ocol + CW'(1);
            end
        end
        if (row_end) begin
            n_col       = '0;
            n_col_phase = '0;
            n_ocol      = '0;
            if (row_fits) begin
                n_row_phase = ((PX'(e_row_phase) + PX'(1)) >= s_eff) ? '0 :
                              SW'(PX'(e_row_phase) + PX'(1));
                if (e_row_phase == '0) begin
                    n_orow = e_orow + RW'(1);
                end
            end
            if ((e_r + PX'(1)) >= h_eff) begin
                n_row       = '0;
                n_row_phase = '0;
                n_slot      = '0;
                n_orow      = '0;
            end else begin
                n_row  = RW'(e_r + PX'(1));
                n_slot = ((PX'(e_slot) + PX'(1)) >= k_eff) ? '0 : SW'(PX'(e_slot) + PX'(1));
            end
        end else begin
            n_col = CW'(e_c + PX'(1));
        end

        wr_addr = {e_slot, e_c[CW-1:0]};
        rd_addr = {r_scan_slot, r_scan_col};
        last_issue = ((PX'(r_scan_j) + PX'(1)) == k_eff) &&
                     ((PX'(r_scan_slot) + PX'(1)) == k_eff);
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && !cfg_err) begin
            r_line_store[wr_addr] <= i_sample;
        end
        r_rd_data <= r_line_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_window_size  <= RST_WINDOW_SIZE;
            r_step         <= RST_STEP;
            r_row          <= '0;
            r_col          <= '0;
            r_row_phase    <= '0;
            r_col_phase    <= '0;
            r_slot         <= '0;
            r_orow         <= '0;
            r_ocol         <= '0;
            r_rd_valid     <= 1'b0;
            r_issuing      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // in S_DONE a taken result is replaced by the next one
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (cfg_err) begin
                            r_best     <= '0;
                            r_res_row  <= '0;
                            r_res_col  <= '0;
                            r_res_done <= 1'b0;
                            r_res_err  <= 1'b1;
                            r_state    <= S_DONE;
                        end else if (hit) begin
                            r_best       <= i_sample;
                            r_res_row    <= OUT_POS_BITS'(PX'(e_orow));
                            r_res_col    <= OUT_POS_BITS'(PX'(e_ocol));
                            r_res_done   <= ((e_r + s_eff) >= h_eff) &&
                                            ((e_c + s_eff) >= w_eff);
                            r_res_err    <= 1'b0;
                            r_scan_slot  <= '0;
                            r_scan_j     <= '0;
                            r_scan_col   <= CW'(e_c + PX'(1) - k_eff);
                            r_scan_start <= CW'(e_c + PX'(1) - k_eff);
                            r_issuing    <= 1'b1;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_valid <= r_issuing;
                    if (r_rd_valid && (r_rd_data > r_best)) begin
                        r_best <= r_rd_data;
                    end
                    if (r_issuing) begin
                        if (last_issue) begin
                            r_issuing <= 1'b0;
                        end else if ((PX'(r_scan_j) + PX'(1)) == k_eff) begin
                            r_scan_j    <= '0;
                            r_scan_col  <= r_scan_start;
                            r_scan_slot <= r_scan_slot + SW'(1);
                        end else begin
                            r_scan_j   <= r_scan_j + SW'(1);
                            r_scan_col <= r_scan_col + CW'(1);
                        end
                    end else if (!r_rd_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_max   <= r_best;
                        r_out_row   <= r_res_row;
                        r_out_col   <= r_res_col;
                        r_out_done  <= r_res_done;
                        r_out_err   <= r_res_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_BITS-1:0];
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_BITS-1:0];
                    REG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WIN_BITS-1:0];
                    REG_STEP:         r_step         <= i_cfg_data[WIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (cfg_restart) begin
                r_row       <= '0;
                r_col       <= '0;
                r_row_phase <= '0;
                r_col_phase <= '0;
                r_slot      <= '0;
                r_orow      <= '0;
                r_ocol      <= '0;
            end else if (in_xfer && !cfg_err) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_row_phase <= n_row_phase;
                r_col_phase <= n_col_phase;
                r_slot      <= n_slot;
                r_orow      <= n_orow;
                r_ocol      <= n_ocol;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pooled_max   = r_out_max;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_plane_done   = r_out_done;
    assign o_config_error = r_out_err;

endmodule

@@ tb/tb_max_pool_2d_stream.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream
// Self-checking bench for the streaming 2-D max pooling block. A clocked
// driver feeds samples from a backlog and predicts each window maximum with
// its own line store and position counters. A clocked monitor compares every
// result transfer with the oldest prediction. Register writes happen only
// while the block is quiet. Runs cover the reset geometry, unusable settings,
// oversized frames and random small frames, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_stream;
    import mp2d_pkg::*;

    localparam int WIN_LIMIT     = DEF_MAX_WINDOW;
    localparam int ROW_LIMIT     = DEF_MAX_HEIGHT;
    localparam int COL_LIMIT     = DEF_MAX_WIDTH;
    localparam int STORE_WORDS   = WIN_LIMIT * COL_LIMIT;
    localparam int SETTLE_CYCLES = 100;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd4;

    typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} t_flow_mode;

    typedef struct packed {
        logic [DEF_SAMPLE_BITS-1:0] pooled_max;
        logic [OUT_POS_BITS-1:0]    out_row;
        logic [OUT_POS_BITS-1:0]    out_col;
        logic                       plane_done;
        logic                       config_error;
    } t_pool_result;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_reg_write;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic signed [DEF_SAMPLE_BITS-1:0] i_sample = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [DEF_SAMPLE_BITS-1:0] o_pooled_max;
    logic [OUT_POS_BITS-1:0]           o_out_row;
    logic [OUT_POS_BITS-1:0]           o_out_col;
    logic                              o_plane_done;
    logic                              o_config_error;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]          i_cfg_data = '0;

    // stimulus backlogs and expected window maxima
    logic [DEF_SAMPLE_BITS-1:0] sample_backlog[$];
    t_reg_write                 reg_backlog[$];
    t_pool_result               pooled_expect[$];

    int unsigned samples_queued = 0;
    int unsigned samples_taken  = 0;
    int unsigned regs_queued    = 0;
    int unsigned regs_taken     = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    // predictor copy of registers, position and line store
    logic [FRAME_BITS-1:0]      reg_height = RST_FRAME_HEIGHT;
    logic [FRAME_BITS-1:0]      reg_width  = RST_FRAME_WIDTH;
    logic [WIN_BITS-1:0]        reg_window = RST_WINDOW_SIZE;
    logic [WIN_BITS-1:0]        reg_stride = RST_STEP;
    int unsigned                pos_row = 0;
    int unsigned                pos_col = 0;
    int unsigned                row_ph  = 0;
    int unsigned                col_ph  = 0;
    logic signed [DEF_SAMPLE_BITS-1:0] line_mem [0:STORE_WORDS-1];

    max_pool_2d_stream u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pooled_max   (o_pooled_max),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_plane_done   (o_plane_done),
        .o_config_error (o_config_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void restart_plane();
        pos_row = 0;
        pos_col = 0;
        row_ph  = 0;
        col_ph  = 0;
    endfunction

    function automatic void apply_reg_write(logic [CFG_INDEX_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_FRAME_HEIGHT: reg_height = data[FRAME_BITS-1:0];
            REG_FRAME_WIDTH:  reg_width  = data[FRAME_BITS-1:0];
            REG_WINDOW_SIZE:  reg_window = data[WIN_BITS-1:0];
            REG_STEP:         reg_stride = data[WIN_BITS-1:0];
            default:          return;
        endcase
        restart_plane();
    endfunction

    // works out the window maximum, if any, that a sample completes
    function automatic void predict_window_max(logic signed [DEF_SAMPLE_BITS-1:0] smp);
        int unsigned h, w, k, s, r, c, orow, ocol, rr, cc;
        logic signed [DEF_SAMPLE_BITS-1:0] best, v;
        t_pool_result res;
        h = (reg_height > ROW_LIMIT) ? ROW_LIMIT : reg_height;
        w = (reg_width > COL_LIMIT) ? COL_LIMIT : reg_width;
        k = reg_window;
        s = (reg_stride == 0) ? k : reg_stride;
        res = '0;
        if (k == 0 || k > WIN_LIMIT || s > WIN_LIMIT || h < k || w < k) begin
            res.config_error = 1'b1;
            pooled_expect.push_back(res);
            return;
        end
        if (pos_row >= h || pos_col >= w)
            restart_plane();
        r = pos_row;
        c = pos_col;
        line_mem[(r % k) * COL_LIMIT + c] = smp;
        if (r + 1 >= k && c + 1 >= k && row_ph == 0 && col_ph == 0) begin
            best = line_mem[(r % k) * COL_LIMIT + c];
            for (int i = 0; i < k; i++) begin
                rr = r + 1 - k + i;
                for (int j = 0; j < k; j++) begin
                    cc = c + 1 - k + j;
                    v = line_mem[(rr % k) * COL_LIMIT + cc];
                    if (v > best)
                        best = v;
                end
            end
            orow = (r + 1 - k) / s;
            ocol = (c + 1 - k) / s;
            res.pooled_max = best;
            res.out_row    = orow[OUT_POS_BITS-1:0];
            res.out_col    = ocol[OUT_POS_BITS-1:0];
            res.plane_done = (orow == (h - k) / s) && (ocol == (w - k) / s);
            pooled_expect.push_back(res);
        end
        if (c + 1 >= k)
            col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
        if (c + 1 >= w) begin
            pos_col = 0;
            col_ph  = 0;
            if (r + 1 >= k)
                row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
            if (r + 1 >= h) begin
                pos_row = 0;
                row_ph  = 0;
            end else begin
                pos_row = r + 1;
            end
        end else begin
            pos_col = c + 1;
        end
    endfunction

    function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predict_window_max(i_sample);
            samples_taken <= samples_taken + 1;
        end
        if (i_rst_n && (!i_valid || o_ready)) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_valid  <= 1'b1;
                i_sample <= sample_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        t_reg_write wr;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            apply_reg_write(i_cfg_index, i_cfg_data);
            regs_taken <= regs_taken + 1;
        end
        if (i_rst_n && (!i_cfg_valid || o_cfg_ready)) begin
            if (reg_backlog.size() != 0) begin
                wr = reg_backlog.pop_front();
                i_cfg_valid <= 1'b1;
                i_cfg_index <= wr.idx;
                i_cfg_data  <= wr.data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pool_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_pooled_max, o_out_row, o_out_col, o_plane_done, o_config_error};
            if (pooled_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transfer: max=%0d row=%0d col=%0d done=%0b err=%0b",
                             $signed(got.pooled_max), got.out_row, got.out_col,
                             got.plane_done, got.config_error);
            end else begin
                want = pooled_expect.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result mismatch: exp max=%0d row=%0d col=%0d done=%0b err=%0b",
                                 $signed(want.pooled_max), want.out_row, want.out_col,
                                 want.plane_done, want.config_error,
                                 " / got max=%0d row=%0d col=%0d done=%0b err=%0b",
                                 $signed(got.pooled_max), got.out_row, got.out_col,
                                 got.plane_done, got.config_error);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic set_flow(t_flow_mode mode);
        case (mode)
            FLOW_SEND_GAPS:   begin send_gap_pct = 79; recv_stall_pct = 0;  end
            FLOW_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 79; end
            FLOW_BOTH:        begin send_gap_pct = 10; recv_stall_pct = 10; end
            default:          begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_sample(logic [DEF_SAMPLE_BITS-1:0] smp);
        sample_backlog.push_back(smp);
        samples_queued++;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_sample(pick_sample());
    endtask

    // all samples taken, all results in, then room for a scan still running
    task automatic drain();
        while (samples_taken != samples_queued || pooled_expect.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        reg_backlog.push_back('{idx: idx, data: data});
        regs_queued++;
        while (regs_taken != regs_queued)
            @(negedge i_clk);
    endtask

    task automatic program_frame(int h, int w, int k, int s);
        drain();
        write_reg(REG_FRAME_HEIGHT, 11'(h));
        write_reg(REG_FRAME_WIDTH, 11'(w));
        write_reg(REG_WINDOW_SIZE, {7'($urandom), 4'(k)});
        write_reg(REG_STEP, {7'($urandom), 4'(s)});
    endtask

    initial begin
        int h, w, k, s, n, pick, seg, random_items;
        bit cfg_ok;
        set_flow(FLOW_FREE);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: two rows of a 32 x 32 plane, window 2
        send_random(64);

        // two 2 x 2 windows on a 2 x 2 plane, both sign extremes
        program_frame(2, 2, 2, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        repeat (4) send_sample(16'h8000);

        // unusable settings
        program_frame(4, 4, 0, 0);
        send_sample(16'h1234);
        program_frame(16, 16, 9, 1);
        send_sample(16'h7FFF);
        program_frame(16, 16, 15, 0);
        send_sample(16'h8000);
        program_frame(16, 16, 2, 9);
        send_sample(16'h0001);
        program_frame(16, 16, 3, 15);
        send_sample(16'h0001);
        program_frame(1, 8, 2, 0);
        send_sample(16'hFFFE);
        program_frame(8, 0, 1, 0);
        send_sample(16'h0002);

        // single sample plane
        program_frame(1, 1, 1, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        // oversized width and height saturate to the maximum
        set_flow(FLOW_SEND_GAPS);
        program_frame(1, 2047, 1, 1);
        send_random(COL_LIMIT + 5);
        set_flow(FLOW_RECV_STALLS);
        program_frame($urandom_range(ROW_LIMIT + 1, 2047), 1, 1, 1);
        send_random(ROW_LIMIT + 5);

        seg = 0;
        random_items = 0;
        cfg_ok = 1'b0;
        h = 1; w = 1; k = 1; s = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            set_flow(t_flow_mode'(seg % 4));
            pick = $urandom_range(19);
            if (pick == 0) begin
                case ($urandom_range(4))
                    0:       program_frame(4, 4, 0, $urandom_range(8));
                    1:       program_frame(9, 9, $urandom_range(9, 15), 0);
                    2:       program_frame(9, 9, 2, $urandom_range(9, 15));
                    3:       program_frame($urandom_range(0, 2), 9, 3, 0);
                    default: program_frame(9, $urandom_range(0, 6), 7, 1);
                endcase
                cfg_ok = 1'b0;
                send_random($urandom_range(1, 3));
            end else if (cfg_ok && pick < 4) begin
                // unmapped index: no effect, the plane carries on
                write_reg(REG_UNMAPPED_LO + CFG_INDEX_BITS'($urandom_range(3)), 11'($urandom));
                n = $urandom_range(1, h * w);
                send_random(n);
                random_items += n;
            end else if (cfg_ok && pick < 8) begin
                s = $urandom_range(0, WIN_LIMIT);
                write_reg(REG_STEP, {7'($urandom), 4'(s)});
                n = $urandom_range(1, 2 * h * w);
                send_random(n);
                random_items += n;
            end else begin
                case ($urandom_range(3))
                    0:       k = 1;
                    1:       k = WIN_LIMIT;
                    default: k = $urandom_range(1, WIN_LIMIT);
                endcase
                case ($urandom_range(3))
                    0:       s = 0;
                    1:       s = WIN_LIMIT;
                    default: s = $urandom_range(0, WIN_LIMIT);
                endcase
                h = k + $urandom_range(0, 3);
                w = ($urandom_range(9) == 0) ? $urandom_range(k, 48) : k + $urandom_range(0, 5);
                program_frame(h, w, k, s);
                cfg_ok = 1'b1;
                n = h * w + $urandom_range(0, h * w);
                send_random(n);
                random_items += n;
            end
            seg++;
        end

        drain();
        if (mismatches == 0 && pooled_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mp2d_pkg.sv
hdl/max_pool_2d_stream.sv
tb/tb_max_pool_2d_stream.sv
